// ===== rtl/sesched_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesched_pkg: shared types and constants
// Floor and counter sizes, request/response structs and the command
// broadcast from the sequencer to the row of floor cells.
// ----------------------------------------------------------------------------
package sesched_pkg;

    localparam int FLOOR_COUNT = 16;
    localparam int COUNT_BITS  = 8;
    localparam int FLOOR_BITS  = $clog2(FLOOR_COUNT);
    localparam int TGT_BITS    = 6;
    localparam int KIND_BITS   = 2;

    localparam logic [KIND_BITS-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_CALL = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd2;

    localparam logic [FLOOR_BITS-1:0] TOP_FLOOR  = FLOOR_BITS'(FLOOR_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [TGT_BITS-1:0]  target_floor;
        logic                 call_up;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] request_count;
        logic [FLOOR_BITS-1:0] car_floor;
        logic                  heading_up;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_BUMP,
        CMD_ARRIVE,
        CMD_CLEAR
    } cmd_op_t;

    typedef enum logic [1:0] {
        SEL_UP,
        SEL_DOWN,
        SEL_DEST
    } ctr_sel_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [FLOOR_BITS-1:0] floor;
        ctr_sel_t              sel;
    } cell_cmd_t;

endpackage

// ===== rtl/scan_elevator_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_elevator_scheduler_top: SCAN elevator car controller
// Sequencer plus a row of floor cells. Calls and dropoffs bump a counter
// at a floor; a tick moves the car, clears served requests and picks the
// next direction from the pending chains that run through the cells.
// ----------------------------------------------------------------------------
// Sequence: a call or dropoff passes S_EXEC then S_DONE; a tick passes
// S_EXEC, S_TURN and S_DONE, as the counter clear in S_EXEC must land before
// the direction scan in S_TURN. A new request is taken in the cycle its
// predecessor's result is registered, so one request is in flight at a time.
// Reset: asynchronous, active low; car at ground floor heading up and all
// counters cleared at once (flip-flops, no clearing pass).
// ----------------------------------------------------------------------------
module scan_elevator_scheduler_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sesched_pkg::in_item_t   in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sesched_pkg::out_item_t  out_item
);

    // S_EXEC: bump a counter, or move the car and clear arrivals
    // S_TURN: tick only, choose direction and clear the new-heading call
    // S_DONE: load the result register when it is free
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TURN,
        S_DONE
    } state_t;

    state_t                             state_reg;
    sesched_pkg::in_item_t              item_reg;
    logic [sesched_pkg::FLOOR_BITS-1:0] pos_reg;
    logic                               up_reg;
    logic [sesched_pkg::COUNT_BITS-1:0] count_reg;
    logic                               out_valid_reg;
    sesched_pkg::out_item_t             out_item_reg;

    sesched_pkg::cell_cmd_t             cmd;
    logic [sesched_pkg::FLOOR_BITS-1:0] move_pos;
    logic [sesched_pkg::FLOOR_BITS-1:0] tgt;
    logic                               is_tick;
    logic                               is_req;
    logic                               in_range;
    logic                               heading_new;
    logic                               out_free;
    logic                               out_load;

    logic                               above_in  [sesched_pkg::FLOOR_COUNT];
    logic                               below_in  [sesched_pkg::FLOOR_COUNT];
    logic                               above_out [sesched_pkg::FLOOR_COUNT];
    logic                               below_out [sesched_pkg::FLOOR_COUNT];
    logic [sesched_pkg::COUNT_BITS-1:0] bump_val  [sesched_pkg::FLOOR_COUNT];

    // ------------------------------------------------------------------
    // Floor cell row. The above chain ripples from the top floor down, so
    // above_in at floor p says whether anything is pending above p; the
    // below chain mirrors it from the ground floor up.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < sesched_pkg::FLOOR_COUNT; i++)
    begin : g_cell
        if (i == sesched_pkg::FLOOR_COUNT - 1)
        begin : g_top
            assign above_in[i] = 1'b0;
        end
        else
        begin : g_mid_a
            assign above_in[i] = above_out[i+1];
        end

        if (i == 0)
        begin : g_gnd
            assign below_in[i] = 1'b0;
        end
        else
        begin : g_mid_b
            assign below_in[i] = below_out[i-1];
        end

        sesched_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .floor_id  (sesched_pkg::FLOOR_BITS'(i)),
            .cmd       (cmd),
            .above_in  (above_in[i]),
            .below_in  (below_in[i]),
            .above_out (above_out[i]),
            .below_out (below_out[i]),
            .bump_val  (bump_val[i])
        );
    end

    // ------------------------------------------------------------------
    // Decode of the held request
    // ------------------------------------------------------------------
    assign is_tick  = (item_reg.kind == sesched_pkg::KIND_TICK);
    assign is_req   = (item_reg.kind == sesched_pkg::KIND_CALL) ||
                      (item_reg.kind == sesched_pkg::KIND_DROP);
    assign in_range = ({1'b0, item_reg.target_floor} <
                       (sesched_pkg::TGT_BITS + 1)'(sesched_pkg::FLOOR_COUNT));
    assign tgt      = item_reg.target_floor[sesched_pkg::FLOOR_BITS-1:0];

    // One floor in the current direction, held at the ends.
    always_comb
    begin
        move_pos = pos_reg;
        if (up_reg)
        begin
            if (pos_reg != sesched_pkg::TOP_FLOOR)
                move_pos = pos_reg + sesched_pkg::FLOOR_BITS'(1);
        end
        else
        begin
            if (pos_reg != '0)
                move_pos = pos_reg - sesched_pkg::FLOOR_BITS'(1);
        end
    end

    // Direction after arrival: forced at the ends, otherwise reverse when
    // nothing is pending ahead.
    always_comb
    begin
        priority if (pos_reg == '0)
            heading_new = 1'b1;
        else if (pos_reg == sesched_pkg::TOP_FLOOR)
            heading_new = 1'b0;
        else if (up_reg)
            heading_new = above_in[pos_reg];
        else
            heading_new = !below_in[pos_reg];
    end

    // Command broadcast to the cells.
    always_comb
    begin
        cmd.op    = sesched_pkg::CMD_NONE;
        cmd.floor = '0;
        cmd.sel   = sesched_pkg::SEL_DEST;
        unique case (state_reg)
            S_EXEC:
            begin
                if (is_tick)
                begin
                    cmd.op    = sesched_pkg::CMD_ARRIVE;
                    cmd.floor = move_pos;
                    cmd.sel   = up_reg ? sesched_pkg::SEL_UP : sesched_pkg::SEL_DOWN;
                end
                else if (is_req && in_range)
                begin
                    cmd.op    = sesched_pkg::CMD_BUMP;
                    cmd.floor = tgt;
                    if (item_reg.kind == sesched_pkg::KIND_DROP)
                        cmd.sel = sesched_pkg::SEL_DEST;
                    else if (item_reg.call_up)
                        cmd.sel = sesched_pkg::SEL_UP;
                    else
                        cmd.sel = sesched_pkg::SEL_DOWN;
                end
            end
            S_TURN:
            begin
                cmd.op    = sesched_pkg::CMD_CLEAR;
                cmd.floor = pos_reg;
                cmd.sel   = heading_new ? sesched_pkg::SEL_UP : sesched_pkg::SEL_DOWN;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes: the result register frees the input side, so the next
    // request can enter while a result is still waiting to be taken.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign in_ready  = (state_reg == S_IDLE) || out_load;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            pos_reg       <= '0;
            up_reg        <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            // taken result drops unless a new one loads in the same cycle
            if (out_ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_item;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    count_reg <= (cmd.op == sesched_pkg::CMD_BUMP) ? bump_val[tgt] : '0;
                    if (is_tick)
                    begin
                        pos_reg   <= move_pos;
                        state_reg <= S_TURN;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_TURN:
                begin
                    up_reg    <= heading_new;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_item_reg.request_count <= count_reg;
                        out_item_reg.car_floor     <= pos_reg;
                        out_item_reg.heading_up    <= up_reg;
                        if (in_valid)
                        begin
                            item_reg  <= in_item;
                            state_reg <= S_EXEC;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sesched_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesched_cell: one floor of the request row
// Holds up, down and destination counters for its floor, applies the
// broadcast command when it is addressed, and extends the pending chains.
// ----------------------------------------------------------------------------
module sesched_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sesched_pkg::FLOOR_BITS-1:0]  floor_id,
    input  sesched_pkg::cell_cmd_t              cmd,
    input  logic                                above_in,
    input  logic                                below_in,
    output logic                                above_out,
    output logic                                below_out,
    output logic [sesched_pkg::COUNT_BITS-1:0]  bump_val
);

    logic [sesched_pkg::COUNT_BITS-1:0] up_reg;
    logic [sesched_pkg::COUNT_BITS-1:0] dn_reg;
    logic [sesched_pkg::COUNT_BITS-1:0] dst_reg;
    logic [sesched_pkg::COUNT_BITS-1:0] sel_val;
    logic                               hit;
    logic                               pending;

    assign hit     = (cmd.floor == floor_id);
    assign pending = (up_reg != '0) || (dn_reg != '0) || (dst_reg != '0);

    // chains: above runs toward ground, below runs toward the top
    assign above_out = pending | above_in;
    assign below_out = pending | below_in;

    always_comb
    begin
        unique case (cmd.sel)
            sesched_pkg::SEL_UP:   sel_val = up_reg;
            sesched_pkg::SEL_DOWN: sel_val = dn_reg;
            default:               sel_val = dst_reg;
        endcase
    end

    // saturating increment of the selected counter
    assign bump_val = (sel_val == sesched_pkg::COUNT_MAX) ? sel_val
                    : sel_val + sesched_pkg::COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= '0;
            dn_reg  <= '0;
            dst_reg <= '0;
        end
        else if (hit)
        begin
            unique case (cmd.op)
                sesched_pkg::CMD_BUMP:
                begin
                    unique case (cmd.sel)
                        sesched_pkg::SEL_UP:   up_reg  <= bump_val;
                        sesched_pkg::SEL_DOWN: dn_reg  <= bump_val;
                        default:               dst_reg <= bump_val;
                    endcase
                end
                sesched_pkg::CMD_ARRIVE:
                begin
                    dst_reg <= '0;
                    if (cmd.sel == sesched_pkg::SEL_UP)
                        up_reg <= '0;
                    else
                        dn_reg <= '0;
                end
                sesched_pkg::CMD_CLEAR:
                begin
                    if (cmd.sel == sesched_pkg::SEL_UP)
                        up_reg <= '0;
                    else
                        dn_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/sesched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesched_checker: port-level checks for the scheduler
// Watches the top level's ports; bound to the top level below.
// ----------------------------------------------------------------------------
module sesched_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input sesched_pkg::out_item_t  out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // the car never faces down at the ground floor
    a_ground_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.car_floor != '0) || out_item.heading_up)
        else $error("car heading down at ground floor");

    // the car never faces up at the top floor
    a_top_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.car_floor == sesched_pkg::TOP_FLOOR)
        |-> !out_item.heading_up)
        else $error("car heading up at top floor");

    // one request at a time: none taken in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

endmodule

bind scan_elevator_scheduler_top sesched_checker u_sesched_checker (.*);
